[rtl/core/cpi_pkg.sv]
// circle pair intersection: shared widths, codes and word types
// no dependencies; imported by every module of the block
package cpi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;

  // derived widths
  localparam int CW    = COORD_BITS;
  localparam int FW    = FRAC_BITS;
  localparam int DW    = CW + 1;            // centre difference, signed
  localparam int MW    = CW;                // magnitude of a centre difference
  localparam int SQW   = 2 * CW + 2;        // squared distance and radius terms
  localparam int RRW   = SQW + 1;           // r1^2 - r2^2, signed
  localparam int NW    = SQW + 2;           // foot numerator n, signed
  localparam int NMW   = NW - 1;            // magnitude of n
  localparam int RADW  = 2 * SQW + 2 * FW;  // square root radicand
  localparam int ROOTW = RADW / 2;          // square root result
  localparam int P1W   = MW + NMW;          // |d| * |n|
  localparam int T1W   = P1W + FW;          // |d| * |n| * 2^F
  localparam int T2W   = MW + ROOTW;        // |d| * root
  localparam int NUMW  = T1W + 2;           // divider numerator
  localparam int DENW  = SQW + 1;           // divider denominator 2*d2
  localparam int QW    = 41;                // quotient bits kept
  localparam int DIV_LAT = QW + 1;
  localparam int OW    = 26;                // output coordinate width
  localparam int RW    = QW + 3;            // placement sum before saturation

  localparam logic [QW-1:0] QCAP    = {1'b1, {(QW-1){1'b0}}};
  localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  // stream words
  localparam int IN_BITS      = 6 * CW;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 2 + 4 * OW;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // queue between front and back
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // point count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // classified pair, front to back
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [NW-1:0] n;
    logic [SQW-1:0]       d2;
    logic [SQW-1:0]       ka;
    logic [SQW-1:0]       kb;
    logic [1:0]           cnt;
  } cpi_item_t;

  // result word
  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [OW-1:0] ax;
    logic signed [OW-1:0] ay;
    logic signed [OW-1:0] bx;
    logic signed [OW-1:0] by;
  } cpi_res_t;

endpackage

[rtl/core/cpi_front.sv]
// circle pair intersection front: differences, squares and classification
// depends on cpi_pkg
module cpi_front import cpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output cpi_item_t             item_o
);

  logic en;
  logic f1_vld_q, f2_vld_q, f3_vld_q;

  logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
  logic [CW-1:0]        in_r1, in_r2;

  logic signed [CW-1:0] f1_x1_q, f1_y1_q;
  logic signed [DW-1:0] f1_dx_q, f1_dy_q;
  logic [CW:0]          f1_rs_q;
  logic signed [CW:0]   f1_rd_q;

  logic signed [CW-1:0]   f2_x1_q, f2_y1_q;
  logic signed [DW-1:0]   f2_dx_q, f2_dy_q;
  logic signed [2*DW-1:0] dxsq_w, dysq_w, difsq_w;
  logic [SQW-1:0]         sumsq_w;
  logic signed [RRW-1:0]  rr_w;
  logic [SQW-1:0]         f2_dxsq_q, f2_dysq_q, f2_sum2_q, f2_dif2_q;
  logic signed [RRW-1:0]  f2_rr_q;

  logic [SQW-1:0] d2_w;
  cpi_item_t      f3_d, f3_q;

  assign en        = !f3_vld_q || item_ready_i;
  assign s_ready_o = en;

  // word unpacking
  assign in_x1 = s_data_i[0*CW +: CW];
  assign in_y1 = s_data_i[1*CW +: CW];
  assign in_r1 = s_data_i[2*CW +: CW];
  assign in_x2 = s_data_i[3*CW +: CW];
  assign in_y2 = s_data_i[4*CW +: CW];
  assign in_r2 = s_data_i[5*CW +: CW];

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= s_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  // products of stage two
  assign dxsq_w  = f1_dx_q * f1_dx_q;
  assign dysq_w  = f1_dy_q * f1_dy_q;
  assign difsq_w = f1_rd_q * f1_rd_q;
  assign sumsq_w = f1_rs_q * f1_rs_q;
  assign rr_w    = $signed({1'b0, f1_rs_q}) * f1_rd_q;

  // distance, foot numerator and classification
  always_comb begin
    d2_w      = f2_dxsq_q + f2_dysq_q;
    f3_d.x1   = f2_x1_q;
    f3_d.y1   = f2_y1_q;
    f3_d.dx   = f2_dx_q;
    f3_d.dy   = f2_dy_q;
    f3_d.d2   = d2_w;
    f3_d.n    = {f2_rr_q[RRW-1], f2_rr_q} + $signed({2'b00, d2_w});
    f3_d.ka   = f2_sum2_q - d2_w;
    f3_d.kb   = d2_w - f2_dif2_q;
    priority if (d2_w == '0 || d2_w > f2_sum2_q || d2_w < f2_dif2_q) begin
      f3_d.cnt = CNT_NONE;
    end else if (d2_w == f2_sum2_q) begin
      f3_d.cnt = CNT_ONE;
    end else begin
      f3_d.cnt = CNT_TWO;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_x1_q   <= in_x1;
      f1_y1_q   <= in_y1;
      f1_dx_q   <= {in_x2[CW-1], in_x2} - {in_x1[CW-1], in_x1};
      f1_dy_q   <= {in_y2[CW-1], in_y2} - {in_y1[CW-1], in_y1};
      f1_rs_q   <= {1'b0, in_r1} + {1'b0, in_r2};
      f1_rd_q   <= $signed({1'b0, in_r1}) - $signed({1'b0, in_r2});
      f2_x1_q   <= f1_x1_q;
      f2_y1_q   <= f1_y1_q;
      f2_dx_q   <= f1_dx_q;
      f2_dy_q   <= f1_dy_q;
      f2_dxsq_q <= dxsq_w;
      f2_dysq_q <= dysq_w;
      f2_dif2_q <= difsq_w;
      f2_sum2_q <= sumsq_w;
      f2_rr_q   <= rr_w;
      f3_q      <= f3_d;
    end
  end

  assign item_valid_o = f3_vld_q;
  assign item_o       = f3_q;

endmodule

[rtl/core/cpi_fifo.sv]
// circle pair intersection: short queue between front and back
// depends on cpi_pkg
module cpi_fifo import cpi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  cpi_item_t wr_item_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output cpi_item_t rd_item_o
);

  cpi_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               push, pop;

  assign wr_ready_o = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_item_i;
  end

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue level beyond depth");
  a_level_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue level missed a write");
  a_level_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue level missed a read");

endmodule

[rtl/core/cpi_isqrt.sv]
// circle pair intersection: pipelined integer square root, one bit per stage
// depends on cpi_pkg
module cpi_isqrt import cpi_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RADW-1:0]  rad_i,
  output logic [ROOTW-1:0] root_o
);

  logic [ROOTW+1:0] rem_q [ROOTW];
  logic [ROOTW+1:0] rem_d [ROOTW];
  logic [ROOTW-1:0] root_q [ROOTW];
  logic [ROOTW-1:0] root_d [ROOTW];
  logic [RADW-1:0]  rad_q [ROOTW];
  logic [RADW-1:0]  rad_d [ROOTW];
  logic [ROOTW+1:0] rin_w [ROOTW];
  logic [ROOTW+1:0] rsh_w [ROOTW];
  logic [ROOTW+1:0] trial_w [ROOTW];
  logic [ROOTW-1:0] oin_w [ROOTW];
  logic [RADW-1:0]  ain_w [ROOTW];

  // one result bit per stage, radicand taken two bits at a time
  always_comb begin
    for (int i = 0; i < ROOTW; i++) begin
      if (i == 0) begin
        rin_w[i] = '0;
        oin_w[i] = '0;
        ain_w[i] = rad_i;
      end else begin
        rin_w[i] = rem_q[i-1];
        oin_w[i] = root_q[i-1];
        ain_w[i] = rad_q[i-1];
      end
      rsh_w[i]   = {rin_w[i][ROOTW-1:0], ain_w[i][RADW-1 -: 2]};
      trial_w[i] = {oin_w[i], 2'b01};
      if (rsh_w[i] >= trial_w[i]) begin
        rem_d[i]  = rsh_w[i] - trial_w[i];
        root_d[i] = {oin_w[i][ROOTW-2:0], 1'b1};
      end else begin
        rem_d[i]  = rsh_w[i];
        root_d[i] = {oin_w[i][ROOTW-2:0], 1'b0};
      end
      rad_d[i] = ain_w[i] << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < ROOTW; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        rad_q[i]  <= rad_d[i];
      end
    end
  end

  assign root_o = root_q[ROOTW-1];

endmodule

[rtl/core/cpi_div.sv]
// circle pair intersection: pipelined restoring divider with overflow flag
// depends on cpi_pkg
module cpi_div import cpi_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   q_o,
  output logic            ovf_o
);

  logic [DENW-1:0] rem_q [QW+1];
  logic [DENW-1:0] rem_d [QW+1];
  logic [DENW-1:0] den_q [QW+1];
  logic [DENW-1:0] den_d [QW+1];
  logic [QW-1:0]   lo_q [QW+1];
  logic [QW-1:0]   lo_d [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [QW-1:0]   quo_d [QW+1];
  logic            ovf_q [QW+1];
  logic            ovf_d [QW+1];
  logic [DENW:0]   rx_w [QW+1];

  // stage zero checks the quotient fits, later stages take one bit each
  always_comb begin
    for (int i = 0; i <= QW; i++) begin
      if (i == 0) begin
        rx_w[i]  = '0;
        rem_d[i] = DENW'(num_i >> QW);
        ovf_d[i] = (num_i >> QW) >= NUMW'(den_i);
        lo_d[i]  = num_i[QW-1:0];
        quo_d[i] = '0;
        den_d[i] = den_i;
      end else begin
        rx_w[i]  = {rem_q[i-1], lo_q[i-1][QW-1]};
        ovf_d[i] = ovf_q[i-1];
        lo_d[i]  = lo_q[i-1] << 1;
        den_d[i] = den_q[i-1];
        if (rx_w[i] >= {1'b0, den_q[i-1]}) begin
          rem_d[i] = DENW'(rx_w[i] - {1'b0, den_q[i-1]});
          quo_d[i] = {quo_q[i-1][QW-2:0], 1'b1};
        end else begin
          rem_d[i] = DENW'(rx_w[i]);
          quo_d[i] = {quo_q[i-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i <= QW; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_d[i];
        lo_q[i]  <= lo_d[i];
        quo_q[i] <= quo_d[i];
        ovf_q[i] <= ovf_d[i];
      end
    end
  end

  assign q_o   = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

[rtl/core/cpi_back.sv]
// circle pair intersection back: root, products, divisions and placement
// depends on cpi_pkg, cpi_isqrt and cpi_div
module cpi_back import cpi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cpi_item_t item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cpi_res_t  res_o
);

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [MW-1:0]        dxm;
    logic [MW-1:0]        dym;
    logic                 dxn;
    logic                 dyn;
    logic [P1W-1:0]       t1x;
    logic [P1W-1:0]       t1y;
    logic                 t1xn;
    logic                 t1yn;
    logic [SQW-1:0]       d2;
    logic [1:0]           cnt;
  } s1_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic                 t1xn;
    logic                 t1yn;
    logic [SQW-1:0]       d2;
    logic [1:0]           cnt;
  } s3_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [3:0]           ng;
    logic [1:0]           cnt;
  } s2_t;

  logic en;

  // stage one
  logic [MW-1:0]    dxm_w, dym_w;
  logic [NMW-1:0]   nm_w;
  logic [2*SQW-1:0] k_w;
  s1_t              b1_side_d, b1_side_q;
  logic [2*SQW-1:0] b1_k_q;
  logic             b1_vld_q;

  // root and its delay line
  logic [ROOTW-1:0] root_w;
  s1_t              sq_side_q [ROOTW];
  logic [ROOTW-1:0] sq_vld_q;
  s1_t              sq_side_w;

  // stage two
  logic [T2W-1:0] t2x_d, t2y_d, b2_t2x_q, b2_t2y_q;
  s1_t            b2_side_q;
  logic           b2_vld_q;

  // stage three
  logic signed [NUMW-1:0] u1x_w, u1y_w, u2x_w, u2y_w;
  logic signed [NUMW-1:0] sx_w, dfx_w, sy_w, dfy_w;
  logic signed [NUMW-1:0] e_d [4];
  logic signed [NUMW-1:0] e_q [4];
  s3_t                    b3_side_d, b3_side_q;
  logic                   b3_vld_q;

  // stage four
  logic signed [NUMW-1:0] d2x_w;
  logic [NUMW-1:0]        num_d [4];
  logic [NUMW-1:0]        num_q [4];
  logic [DENW-1:0]        den_q;
  s2_t                    b4_side_d, b4_side_q;
  logic                   b4_vld_q;

  // divisions and their delay line
  logic [QW-1:0]      q_w [4];
  logic [3:0]         ovf_w;
  s2_t                dv_side_q [DIV_LAT];
  logic [DIV_LAT-1:0] dv_vld_q;
  s2_t                dv_side_w;

  // output register
  cpi_res_t res_d, res_q;
  logic     out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // placement of one coordinate from base, quotient and sign
  function automatic logic signed [OW-1:0] place_f(logic signed [CW-1:0] base,
                                                   logic [QW-1:0] q, logic ovf,
                                                   logic neg);
    logic [QW-1:0]        qm;
    logic signed [RW-1:0] b;
    logic signed [RW-1:0] r;
    qm = (ovf || q > QCAP) ? QCAP : q;
    b  = {{(RW-CW-FW){base[CW-1]}}, base, {FW{1'b0}}};
    r  = neg ? b - $signed({3'b000, qm}) : b + $signed({3'b000, qm});
    if (r[RW-1:OW-1] == '0 || r[RW-1:OW-1] == '1) begin
      place_f = r[OW-1:0];
    end else begin
      place_f = r[RW-1] ? OUT_MIN : OUT_MAX;
    end
    return place_f;
  endfunction

  // magnitudes, k product and foot products
  assign dxm_w = item_i.dx[DW-1] ? MW'(-item_i.dx) : MW'(item_i.dx);
  assign dym_w = item_i.dy[DW-1] ? MW'(-item_i.dy) : MW'(item_i.dy);
  assign nm_w  = item_i.n[NW-1] ? NMW'(-item_i.n) : NMW'(item_i.n);
  assign k_w   = item_i.ka * item_i.kb;

  always_comb begin
    b1_side_d.x1   = item_i.x1;
    b1_side_d.y1   = item_i.y1;
    b1_side_d.dxm  = dxm_w;
    b1_side_d.dym  = dym_w;
    b1_side_d.dxn  = item_i.dx[DW-1];
    b1_side_d.dyn  = item_i.dy[DW-1];
    b1_side_d.t1x  = dxm_w * nm_w;
    b1_side_d.t1y  = dym_w * nm_w;
    b1_side_d.t1xn = item_i.dx[DW-1] ^ item_i.n[NW-1];
    b1_side_d.t1yn = item_i.dy[DW-1] ^ item_i.n[NW-1];
    b1_side_d.d2   = item_i.d2;
    b1_side_d.cnt  = item_i.cnt;
  end

  cpi_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({b1_k_q, {(2*FW){1'b0}}}),
    .root_o (root_w)
  );

  assign sq_side_w = sq_side_q[ROOTW-1];
  assign t2x_d     = sq_side_w.dym * root_w;
  assign t2y_d     = sq_side_w.dxm * root_w;

  // signed sums relative to the sign of the foot term
  always_comb begin
    u1x_w = $signed({{(NUMW-T1W){1'b0}}, b2_side_q.t1x, {FW{1'b0}}});
    u1y_w = $signed({{(NUMW-T1W){1'b0}}, b2_side_q.t1y, {FW{1'b0}}});
    u2x_w = $signed({{(NUMW-T2W){1'b0}}, b2_t2x_q});
    u2y_w = $signed({{(NUMW-T2W){1'b0}}, b2_t2y_q});
    sx_w  = u1x_w + u2x_w;
    dfx_w = u1x_w - u2x_w;
    sy_w  = u1y_w + u2y_w;
    dfy_w = u1y_w - u2y_w;
    e_d[0] = (b2_side_q.t1xn == b2_side_q.dyn) ? sx_w : dfx_w;
    e_d[2] = (b2_side_q.t1xn == b2_side_q.dyn) ? dfx_w : sx_w;
    e_d[1] = (b2_side_q.t1yn != b2_side_q.dxn) ? sy_w : dfy_w;
    e_d[3] = (b2_side_q.t1yn != b2_side_q.dxn) ? dfy_w : sy_w;
    b3_side_d.x1   = b2_side_q.x1;
    b3_side_d.y1   = b2_side_q.y1;
    b3_side_d.t1xn = b2_side_q.t1xn;
    b3_side_d.t1yn = b2_side_q.t1yn;
    b3_side_d.d2   = b2_side_q.d2;
    b3_side_d.cnt  = b2_side_q.cnt;
  end

  // rounding numerators |sum| + d2 and the final signs
  always_comb begin
    d2x_w = $signed({{(NUMW-SQW){1'b0}}, b3_side_q.d2});
    for (int i = 0; i < 4; i++) begin
      num_d[i] = e_q[i][NUMW-1] ? $unsigned(d2x_w - e_q[i]) : $unsigned(d2x_w + e_q[i]);
    end
    b4_side_d.x1    = b3_side_q.x1;
    b4_side_d.y1    = b3_side_q.y1;
    b4_side_d.ng[0] = b3_side_q.t1xn ^ e_q[0][NUMW-1];
    b4_side_d.ng[1] = b3_side_q.t1yn ^ e_q[1][NUMW-1];
    b4_side_d.ng[2] = b3_side_q.t1xn ^ e_q[2][NUMW-1];
    b4_side_d.ng[3] = b3_side_q.t1yn ^ e_q[3][NUMW-1];
    b4_side_d.cnt   = b3_side_q.cnt;
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    cpi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[g]),
      .den_i (den_q),
      .q_o   (q_w[g]),
      .ovf_o (ovf_w[g])
    );
  end

  assign dv_side_w = dv_side_q[DIV_LAT-1];

  // placement, saturation and unused points cleared
  always_comb begin
    res_d.cnt = dv_side_w.cnt;
    res_d.ax  = place_f(dv_side_w.x1, q_w[0], ovf_w[0], dv_side_w.ng[0]);
    res_d.ay  = place_f(dv_side_w.y1, q_w[1], ovf_w[1], dv_side_w.ng[1]);
    res_d.bx  = place_f(dv_side_w.x1, q_w[2], ovf_w[2], dv_side_w.ng[2]);
    res_d.by  = place_f(dv_side_w.y1, q_w[3], ovf_w[3], dv_side_w.ng[3]);
    unique case (dv_side_w.cnt)
      CNT_NONE: begin
        res_d.ax = '0;
        res_d.ay = '0;
        res_d.bx = '0;
        res_d.by = '0;
      end
      CNT_ONE: begin
        res_d.bx = '0;
        res_d.by = '0;
      end
      default: ;
    endcase
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      b4_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      b1_vld_q  <= in_valid_i;
      sq_vld_q  <= {sq_vld_q[ROOTW-2:0], b1_vld_q};
      b2_vld_q  <= sq_vld_q[ROOTW-1];
      b3_vld_q  <= b2_vld_q;
      b4_vld_q  <= b3_vld_q;
      dv_vld_q  <= {dv_vld_q[DIV_LAT-2:0], b4_vld_q};
      out_vld_q <= dv_vld_q[DIV_LAT-1];
    end
  end

  // payload stages and delay lines
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_k_q       <= k_w;
      b1_side_q    <= b1_side_d;
      sq_side_q[0] <= b1_side_q;
      for (int i = 1; i < ROOTW; i++) sq_side_q[i] <= sq_side_q[i-1];
      b2_t2x_q     <= t2x_d;
      b2_t2y_q     <= t2y_d;
      b2_side_q    <= sq_side_w;
      for (int i = 0; i < 4; i++) e_q[i] <= e_d[i];
      b3_side_q    <= b3_side_d;
      for (int i = 0; i < 4; i++) num_q[i] <= num_d[i];
      den_q        <= {b3_side_q.d2, 1'b0};
      b4_side_q    <= b4_side_d;
      dv_side_q[0] <= b4_side_q;
      for (int i = 1; i < DIV_LAT; i++) dv_side_q[i] <= dv_side_q[i-1];
      res_q        <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  a_cnt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.cnt == CNT_NONE || res_q.cnt == CNT_ONE || res_q.cnt == CNT_TWO)
    else $error("point count code out of range");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.cnt == CNT_NONE |->
      res_q.ax == '0 && res_q.ay == '0 && res_q.bx == '0 && res_q.by == '0)
    else $error("points set with no intersection");
  a_one_zero_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.cnt == CNT_ONE |-> res_q.bx == '0 && res_q.by == '0)
    else $error("second point set at tangency");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> b1_vld_q == $past(b1_vld_q) && b4_vld_q == $past(b4_vld_q))
    else $error("pipeline moved during a stall");

endmodule

[rtl/core/circle_pair_intersection_top.sv]
// circle pair intersection top: stream ports, front, queue and back
// depends on cpi_pkg, cpi_front, cpi_fifo and cpi_back
//
//  channel  | dir | handshake                  | word
//  s_axis   | in  | s_axis_tvalid/tready       | two circles, centre and radius each
//  m_axis   | out | m_axis_tvalid/tready       | point count and two fixed-point points
//
// one word in per cycle, one word out per cycle, sustained while m_axis_tready stays high
// pipeline order: front, queue, product, 42 root stages, sum, divider, output register
// root and divider produce one result bit per stage, which sets the depth
// reset clears only valids, queue pointers and queue fill level; payload is undefined until loaded
// an output stall freezes the back; the front keeps filling the 4-word queue
module circle_pair_intersection_top import cpi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x1, y1, r1, x2, y2, r2 from bit 0 up, 16 bits each
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // point_count, point_a_x, point_a_y, point_b_x, point_b_y from bit 0 up, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  cpi_item_t fr_item, bk_item;
  cpi_res_t  res;

  cpi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  cpi_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_item_o  (bk_item)
  );

  cpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .item_i      (bk_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // result word packing
  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                         res.by, res.bx, res.ay, res.ax, res.cnt};

endmodule
